@@ hdl/ssq_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants of the smallest subsequence selector
// no dependencies

package ssq_pkg;

	localparam int DEPTH = 1024;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int OCC_W = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;
	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_SEQ_LENGTH = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_KEEP_COUNT = CFG_IDX_W'(1);

	localparam logic [CFG_W-1:0] EMIT_CAP = CFG_W'(DEPTH - 1);

	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [OCC_W-1:0] occ_t;
	typedef logic [DATA_W-1:0] data_t;
	typedef logic [CFG_W-1:0] cfg_t;

	typedef struct packed {
		logic  we;
		ptr_t  waddr;
		data_t wdata;
		logic  re;
		ptr_t  raddr;
	} ssq_mem_req_t;

	typedef struct packed {
		logic restart;
		logic out_free;
		cfg_t n;
		cfg_t emit_from;
	} ssq_ctl_t;

	typedef struct packed {
		logic  valid;
		data_t data;
		logic  last;
	} ssq_res_t;

	function automatic ptr_t next_ptr(input ptr_t p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	function automatic ptr_t prev_ptr(input ptr_t p);
		return (p == '0) ? PTR_W'(DEPTH - 1) : p - PTR_W'(1);
	endfunction

endpackage

@@ hdl/ssq_deque_mem.sv @@
`timescale 1ns / 1ps
// candidate store: one write port and one registered read port
// depends on ssq_pkg

module ssq_deque_mem
	import ssq_pkg::*;
(
	input  logic         clk,
	input  ssq_mem_req_t req,
	output data_t        rdata
);

	data_t mem_q [DEPTH];
	data_t rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem_q[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hdl/ssq_ctrl.sv @@
`timescale 1ns / 1ps
// sequencer of the deque: back pops through one shared compare, push, front pop
// depends on ssq_pkg

module ssq_ctrl
	import ssq_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_take,
	input  data_t        in_value,
	input  ssq_ctl_t     ctl,
	input  data_t        mem_rdata,
	output ssq_mem_req_t mem_req,
	output ssq_res_t     res,
	output logic         idle
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_POP   = 5'b00010,
		ST_PUSH  = 5'b00100,
		ST_FRONT = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	state_t state_q, state_d;
	ptr_t   front_q, front_d;
	ptr_t   back_q, back_d;
	occ_t   occ_q, occ_d;
	cfg_t   pos_q, pos_d;
	data_t  value_q;

	logic   last;
	logic   emit;
	logic   larger;
	logic   full;

	assign last   = ({1'b0, pos_q} + 17'd1) >= {1'b0, ctl.n};
	assign emit   = pos_q >= ctl.emit_from;
	assign larger = $signed(mem_rdata) > $signed(value_q);
	assign full   = occ_q == OCC_W'(DEPTH);
	assign idle   = state_q == ST_IDLE;

	always_comb begin
		state_d = state_q;
		front_d = front_q;
		back_d  = back_q;
		occ_d   = occ_q;
		pos_d   = pos_q;
		mem_req = '0;
		res     = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (ctl.restart) begin
					front_d = '0;
					back_d  = '0;
					occ_d   = '0;
					pos_d   = '0;
				end else if (in_take) begin
					if (occ_q != '0) begin
						mem_req.re    = 1'b1;
						mem_req.raddr = prev_ptr(back_q);
						state_d       = ST_POP;
					end else begin
						state_d = ST_PUSH;
					end
				end
			end
			ST_POP: begin
				if (larger) begin
					back_d = prev_ptr(back_q);
					occ_d  = occ_q - OCC_W'(1);
					if (occ_q > OCC_W'(1)) begin
						mem_req.re    = 1'b1;
						mem_req.raddr = prev_ptr(prev_ptr(back_q));
					end else begin
						state_d = ST_PUSH;
					end
				end else begin
					state_d = ST_PUSH;
				end
			end
			ST_PUSH: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = back_q;
				mem_req.wdata = value_q;
				back_d        = next_ptr(back_q);
				if (full) begin
					front_d = next_ptr(front_q);
				end else begin
					occ_d = occ_q + OCC_W'(1);
				end
				if (emit) begin
					state_d = ST_FRONT;
				end else begin
					state_d = ST_IDLE;
					if (last) begin
						front_d = '0;
						back_d  = '0;
						occ_d   = '0;
						pos_d   = '0;
					end else begin
						pos_d = pos_q + CFG_W'(1);
					end
				end
			end
			ST_FRONT: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = front_q;
				state_d       = ST_OUT;
			end
			ST_OUT: begin
				if (ctl.out_free) begin
					res.valid = 1'b1;
					res.data  = mem_rdata;
					res.last  = last;
					front_d   = next_ptr(front_q);
					occ_d     = occ_q - OCC_W'(1);
					state_d   = ST_IDLE;
					if (last) begin
						front_d = '0;
						back_d  = '0;
						occ_d   = '0;
						pos_d   = '0;
					end else begin
						pos_d = pos_q + CFG_W'(1);
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			front_q <= '0;
			back_q  <= '0;
			occ_q   <= '0;
			pos_q   <= '0;
		end else begin
			state_q <= state_d;
			front_q <= front_d;
			back_q  <= back_d;
			occ_q   <= occ_d;
			pos_q   <= pos_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			value_q <= in_value;
		end
	end

endmodule

@@ hdl/smallest_subsequence_selector.sv @@
`timescale 1ns / 1ps
// Smallest subsequence selector: picks the lexicographically smallest
// subsequence of keep_count out of each sequence of seq_length signed values.
// Channels: s_* takes one value per item, m_* gives picked values with tlast on
// the last pick of a sequence, cfg_* writes seq_length (index 0) and keep_count
// (index 1); any write to either restarts the sequence.
// An item goes through the back compares of the deque (none when it is empty),
// then the push, and when it produces a result also the front read and the
// hand-over; each compare reads the candidate memory through its single read
// port. s_tready is low while an item is being worked on.
// m_tvalid is registered from the hand-over, which waits until the output
// register is free.
// A finished result sits in the output register; while the receiver stalls the
// next item is still taken and worked until it has its own result to hand over.
// Reset empties the deque, clears the position and sets both registers to 1.
// The candidate memory itself is not cleared: only written entries are read.
// depends on ssq_pkg, ssq_deque_mem, ssq_ctrl

module smallest_subsequence_selector
	import ssq_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [DATA_W-1:0]    s_tdata,   // value
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [DATA_W-1:0]    m_tdata,   // picked
	output logic                 m_tlast,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	cfg_t         seq_length_q;
	cfg_t         keep_count_q;
	cfg_t         n_eff;
	cfg_t         k_eff;
	cfg_t         span;
	ssq_ctl_t     ctl;
	ssq_mem_req_t mem_req;
	ssq_res_t     res;
	data_t        mem_rdata;
	logic         idle;
	logic         cfg_take;
	logic         m_tvalid_q;
	data_t        m_tdata_q;
	logic         m_tlast_q;

	assign cfg_ready = idle;
	assign s_tready  = idle && !cfg_valid;
	assign cfg_take  = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_length_q <= CFG_W'(1);
			keep_count_q <= CFG_W'(1);
		end else if (cfg_take) begin
			if (cfg_index == REG_SEQ_LENGTH) begin
				seq_length_q <= cfg_data;
			end
			if (cfg_index == REG_KEEP_COUNT) begin
				keep_count_q <= cfg_data;
			end
		end
	end

	// effective lengths, emit start capped so the deque never overflows
	always_comb begin
		n_eff = (seq_length_q == '0) ? CFG_W'(1) : seq_length_q;
		k_eff = (keep_count_q == '0) ? CFG_W'(1) : keep_count_q;
		if (k_eff > n_eff) begin
			k_eff = n_eff;
		end
		span = n_eff - k_eff;
	end

	assign ctl.restart   = cfg_take &&
		(cfg_index == REG_SEQ_LENGTH || cfg_index == REG_KEEP_COUNT);
	assign ctl.out_free  = !m_tvalid_q || m_tready;
	assign ctl.n         = n_eff;
	assign ctl.emit_from = (span > EMIT_CAP) ? EMIT_CAP : span;

	ssq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_take   (s_tvalid && s_tready),
		.in_value  (s_tdata),
		.ctl       (ctl),
		.mem_rdata (mem_rdata),
		.mem_req   (mem_req),
		.res       (res),
		.idle      (idle)
	);

	ssq_deque_mem u_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res.valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			m_tdata_q <= res.data;
			m_tlast_q <= res.last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

@@ hdl/ssq_checker.sv @@
`timescale 1ns / 1ps
// port-level checks of the smallest subsequence selector, bound to the top level
// depends on ssq_pkg and smallest_subsequence_selector

module ssq_checker
	import ssq_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [DATA_W-1:0]    m_tdata,
	input logic                 m_tlast,
	input logic                 cfg_valid,
	input logic                 cfg_ready
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

	// one item at a time
	a_busy_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("item taken while busy");

	// register write and item never share an edge
	a_cfg_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |-> !(s_tvalid && s_tready))
		else $error("register write and item at once");

	// a result never rises right after its item is taken
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result one cycle after item");

	// register port closed while an item is worked on
	a_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !cfg_ready)
		else $error("register port open while busy");

endmodule

bind smallest_subsequence_selector ssq_checker u_ssq_checker (.*);
